// File: hw/rtl/bitplane_sprite_xor_draw_macros.svh
// ----------------------------------------------------------------------------
// Sprite draw assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef BITPLANE_SPRITE_XOR_DRAW_MACROS_SVH
`define BITPLANE_SPRITE_XOR_DRAW_MACROS_SVH

// same-cycle implication
`define BSX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bsx_pkg.sv
// ----------------------------------------------------------------------------
// Sprite draw package
// Types, codes and screen constants shared by the sprite draw block.
// ----------------------------------------------------------------------------
package bsx_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);

    // item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // result kinds
    localparam logic RK_COLLISION = 1'b0;
    localparam logic RK_PIXEL     = 1'b1;

    // configuration register indexes
    localparam logic CFG_HIGH_RES = 1'b0;
    localparam logic CFG_CLIP     = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_FLUSH,
        S_DONE,
        S_READ,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [1:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

endpackage

// File: hw/rtl/bsx_store.sv
// ----------------------------------------------------------------------------
// Sprite draw pixel store
// Two-bit pixel memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsx_store (
    input  logic               i_clk,
    input  bsx_pkg::t_store_req i_req,
    output logic [1:0]         o_rd_data
);

    logic [1:0] r_mem [bsx_pkg::STORE_SIZE];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/bitplane_sprite_xor_draw.sv
// ----------------------------------------------------------------------------
// Bitplane sprite XOR draw
// Two-plane framebuffer with XOR row drawing, clear and pixel read.
// ----------------------------------------------------------------------------
// One item is handled at a time. A draw word shifts its row bits out one pixel
// per cycle and read-modify-writes the pixel store through a read port and a
// write port; a flush state then lets a pending pixel write reach the store.
// A read issues a store read and then returns the pixel. A clear sweeps the
// store one pixel per cycle. After reset the same sweep runs with the input
// stalled; configuration writes are taken throughout.
// A result sits in an output register, so a stalled consumer only holds the
// block when a second result is ready.
`include "bitplane_sprite_xor_draw_macros.svh"

module bitplane_sprite_xor_draw (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_x_pos,
    input  logic [7:0]  i_y_pos,
    input  logic [3:0]  i_row_index,
    input  logic [15:0] i_row_bits,
    input  logic        i_wide_row,
    input  logic        i_plane_select,
    input  logic        i_first_row,
    input  logic        i_last_row,
    input  logic [12:0] i_pixel_index,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic        o_collision,
    output logic [1:0]  o_pixel_value
);

    bsx_pkg::t_state     r_state, n_state;
    bsx_pkg::t_store_req s_req;

    logic                         r_hires, r_clip;
    logic [bsx_pkg::ADDR_W-1:0]   r_clr_cnt;
    logic [15:0]                  r_bits;
    logic [3:0]                   r_col;
    logic                         r_wide, r_plane, r_last;
    logic [7:0]                   r_xm;
    logic [5:0]                   r_yw;
    logic                         r_yclip;
    logic [bsx_pkg::ADDR_W-1:0]   r_pix;
    logic                         r_p_valid;
    logic [bsx_pkg::ADDR_W-1:0]   r_p_addr;
    logic                         r_flag, n_flag;
    logic                         r_out_valid, r_out_kind, r_out_coll;
    logic [1:0]                   r_out_pix;

    logic [1:0]                   s_rd_data;
    logic                         s_accept, s_out_free, s_load_coll, s_load_pix;
    logic                         s_draw_step;
    logic [7:0]                   s_x_sum, s_xm_in, s_y_sum;
    logic                         s_xclip, s_pix_on, s_col_end;
    logic [bsx_pkg::ADDR_W-1:0]   s_addr;
    logic [1:0]                   s_mask;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hires <= 1'b0;
            r_clip  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bsx_pkg::CFG_HIGH_RES: r_hires <= i_cfg_data;
                bsx_pkg::CFG_CLIP:     r_clip  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- coordinate math ----------------
    assign s_accept   = i_in_valid && !o_in_stall;
    assign s_out_free = !r_out_valid || !i_out_stall;

    assign s_xm_in = r_hires ? {1'b0, i_x_pos[6:0]} : {2'b00, i_x_pos[5:0]};
    assign s_y_sum = (r_hires ? {2'b00, i_y_pos[5:0]} : {3'b000, i_y_pos[4:0]})
                   + {4'b0000, i_row_index};

    assign s_x_sum  = r_xm + {4'b0000, r_col};
    assign s_xclip  = r_clip && (r_hires ? s_x_sum[7] : (s_x_sum[7] | s_x_sum[6]));
    assign s_addr   = r_hires ? {r_yw, s_x_sum[6:0]}
                              : {2'b00, r_yw[4:0], s_x_sum[5:0]};
    assign s_pix_on = r_bits[15] && !s_xclip && !r_yclip;
    assign s_col_end = r_wide ? (r_col == 4'd15) : (r_col == 4'd7);
    assign s_mask    = r_plane ? 2'b10 : 2'b01;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsx_pkg::S_CLEAR:
                if (&r_clr_cnt) n_state = bsx_pkg::S_IDLE;
            bsx_pkg::S_IDLE:
                if (s_accept) begin
                    case (i_kind)
                        bsx_pkg::KIND_CLEAR: n_state = bsx_pkg::S_CLEAR;
                        bsx_pkg::KIND_DRAW:  n_state = bsx_pkg::S_DRAW;
                        bsx_pkg::KIND_READ:  n_state = bsx_pkg::S_READ;
                        default:             n_state = bsx_pkg::S_IDLE;
                    endcase
                end
            bsx_pkg::S_DRAW:
                if (s_col_end) n_state = bsx_pkg::S_FLUSH;
            bsx_pkg::S_FLUSH:  n_state = bsx_pkg::S_DONE;
            bsx_pkg::S_DONE:
                if (!r_last || s_out_free) n_state = bsx_pkg::S_IDLE;
            bsx_pkg::S_READ:   n_state = bsx_pkg::S_RDWAIT;
            bsx_pkg::S_RDWAIT:
                if (s_out_free) n_state = bsx_pkg::S_IDLE;
            default:           n_state = bsx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        s_draw_step = 1'b0;
        s_load_coll = 1'b0;
        s_load_pix  = 1'b0;
        s_req.re    = 1'b0;
        s_req.raddr = s_addr;
        // pending pixel write from the previous draw cycle
        s_req.we    = r_p_valid;
        s_req.waddr = r_p_addr;
        s_req.wdata = s_rd_data ^ s_mask;
        case (r_state)
            bsx_pkg::S_CLEAR: begin
                s_req.we    = 1'b1;
                s_req.waddr = r_clr_cnt;
                s_req.wdata = 2'b00;
            end
            bsx_pkg::S_IDLE:   o_in_stall = 1'b0;
            bsx_pkg::S_DRAW: begin
                s_draw_step = 1'b1;
                s_req.re    = s_pix_on;
            end
            bsx_pkg::S_DONE:   s_load_coll = r_last && s_out_free;
            bsx_pkg::S_READ: begin
                s_req.re    = 1'b1;
                s_req.raddr = r_pix;
            end
            bsx_pkg::S_RDWAIT: s_load_pix = s_out_free;
            default: ;
        endcase
    end

    // collision flag: cleared by a first row, set when a lit pixel is erased
    always_comb begin
        n_flag = r_flag;
        if (s_accept && i_kind == bsx_pkg::KIND_DRAW && i_first_row) begin
            n_flag = 1'b0;
        end else if (r_p_valid && |(s_rd_data & s_mask)) begin
            n_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsx_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_p_valid   <= 1'b0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flag    <= n_flag;
            r_p_valid <= s_draw_step && s_pix_on;
            if (r_state == bsx_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + {{(bsx_pkg::ADDR_W-1){1'b0}}, 1'b1};
            end else begin
                r_clr_cnt <= '0;
            end
            if (s_load_coll || s_load_pix) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_p_addr <= s_addr;
        if (s_accept) begin
            r_bits  <= i_wide_row ? i_row_bits : {i_row_bits[15:8], 8'h00};
            r_col   <= 4'd0;
            r_wide  <= i_wide_row;
            r_plane <= i_plane_select;
            r_last  <= i_last_row;
            r_xm    <= s_xm_in;
            r_yw    <= r_hires ? s_y_sum[5:0] : {1'b0, s_y_sum[4:0]};
            r_yclip <= r_clip && (r_hires ? |s_y_sum[7:6] : |s_y_sum[7:5]);
            r_pix   <= i_pixel_index;
        end else if (s_draw_step) begin
            r_bits <= {r_bits[14:0], 1'b0};
            r_col  <= r_col + 4'd1;
        end
        if (s_load_coll) begin
            r_out_kind <= bsx_pkg::RK_COLLISION;
            r_out_coll <= r_flag;
            r_out_pix  <= 2'b00;
        end else if (s_load_pix) begin
            r_out_kind <= bsx_pkg::RK_PIXEL;
            r_out_coll <= 1'b0;
            r_out_pix  <= s_rd_data;
        end
    end

    bsx_store u_store (
        .i_clk     (i_clk),
        .i_req     (s_req),
        .o_rd_data (s_rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_collision   = r_out_coll;
    assign o_pixel_value = r_out_pix;

    // ---------------- assertions ----------------
    `BSX_ASSERT_NOW(a_clear_no_pending, i_clk, i_rst_n, r_state == bsx_pkg::S_CLEAR, !r_p_valid, "pixel write pending during clear sweep")
    `BSX_ASSERT_NOW(a_narrow_col, i_clk, i_rst_n, r_state == bsx_pkg::S_DRAW && !r_wide, !r_col[3], "narrow row column out of range")
    `BSX_ASSERT_NEXT(a_report_out, i_clk, i_rst_n, r_state == bsx_pkg::S_DONE && r_last && s_out_free, o_out_valid && o_result_kind == bsx_pkg::RK_COLLISION, "collision word missing after last row")

endmodule
